[src/urbs_pkg.sv]
`timescale 1ns / 1ps

package urbs_pkg;

   // Fixed sizes of the LED bar and of the distance result.
   localparam int LED_COUNT  = 8;
   localparam int DIST_WIDTH = 10;

   // Configuration register widths.
   localparam int TPMS_WIDTH = 16;
   localparam int MS_WIDTH   = 10;
   localparam int TPCM_WIDTH = 16;
   localparam int STEP_WIDTH = 8;

   // Configuration port shape.
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 16;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_TICKS_PER_MS = 3'd0,
      CSR_TRIGGER_MS   = 3'd1,
      CSR_FLASH_MS     = 3'd2,
      CSR_BAR_MS       = 3'd3,
      CSR_TICKS_PER_CM = 3'd4,
      CSR_BAR_STEP_CM  = 3'd5
   } csr_index_type;

   // Register values after reset.
   localparam logic [TPMS_WIDTH-1:0] TICKS_PER_MS_RESET = 16'd16000;
   localparam logic [MS_WIDTH-1:0]   TRIGGER_MS_RESET   = 10'd500;
   localparam logic [MS_WIDTH-1:0]   FLASH_MS_RESET     = 10'd2;
   localparam logic [MS_WIDTH-1:0]   BAR_MS_RESET       = 10'd600;
   localparam logic [TPCM_WIDTH-1:0] TICKS_PER_CM_RESET = 16'd928;
   localparam logic [STEP_WIDTH-1:0] BAR_STEP_CM_RESET  = 8'd10;

   // One sample beat.
   typedef struct packed {
      logic echo_level;
      logic swing_level;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic                  trigger_out;
      logic [LED_COUNT-1:0]  led_pattern;
      logic                  distance_valid;
      logic [DIST_WIDTH-1:0] range_cm;
   } rsp_type;

endpackage

[src/urbs_bar.sv]
`timescale 1ns / 1ps

module urbs_bar (
   input  logic [urbs_pkg::DIST_WIDTH-1:0] distance,
   input  logic [urbs_pkg::STEP_WIDTH-1:0] step_cm,
   output logic [urbs_pkg::LED_COUNT-1:0]  bar
);
   import urbs_pkg::*;

   localparam int CMP_WIDTH = DIST_WIDTH + STEP_WIDTH;

   logic [STEP_WIDTH-1:0] step_eff;
   logic [CMP_WIDTH-1:0]  threshold [LED_COUNT];

   // A zero step behaves as a one-centimetre step.
   assign step_eff = (step_cm == '0) ? STEP_WIDTH'(1) : step_cm;

   // LED i is lit when the distance reaches i steps, which gives the
   // thermometer of floor(distance / step) + 1 lit LEDs, capped by the bar.
   always_comb begin
      for (int i = 0; i < LED_COUNT; i++) begin
         threshold[i] = CMP_WIDTH'(i) * CMP_WIDTH'(step_eff);
         bar[i]       = (CMP_WIDTH'(distance) >= threshold[i]);
      end
   end

endmodule

[src/ultrasonic_range_bar_sequencer.sv]
`timescale 1ns / 1ps

// Ultrasonic range bar sequencer. Each req beat is one clock-tick sample of
// the echo line and the pendulum side line, and each one yields exactly one
// rsp beat with the trigger drive, the LED pattern, a one-beat distance_valid
// pulse and the last distance in whole centimetres. A sample passes
// through a single register stage, so a new beat is accepted in every cycle;
// the only stall comes from rsp_ready, and the rsp register lets one more
// beat in as soon as the held result is taken. Beat by beat the sequencer
// waits for the left side, flashes all LEDs, holds the trigger high, waits
// for and times the echo, then waits for the right side, flashes again and
// shows a distance bar. All durations count beats. Echo waits never time out.
// Write configuration via csr_we/csr_addr/csr_wdata only while idle (unchecked).
module ultrasonic_range_bar_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  urbs_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output urbs_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [urbs_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [urbs_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);
   import urbs_pkg::*;

   typedef enum logic [2:0] {
      PH_WAIT_LEFT  = 3'd0,
      PH_FLASH_A    = 3'd1,
      PH_TRIG_HIGH  = 3'd2,
      PH_WAIT_RISE  = 3'd3,
      PH_MEASURE    = 3'd4,
      PH_WAIT_RIGHT = 3'd5,
      PH_FLASH_B    = 3'd6,
      PH_BAR        = 3'd7
   } phase_type;

   localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;
   localparam logic [LED_COUNT-1:0]  LED_ALL  = '1;

   // Configuration registers.
   logic [TPMS_WIDTH-1:0] ticks_per_ms_ff;
   logic [MS_WIDTH-1:0]   trigger_ms_ff;
   logic [MS_WIDTH-1:0]   flash_ms_ff;
   logic [MS_WIDTH-1:0]   bar_ms_ff;
   logic [TPCM_WIDTH-1:0] ticks_per_cm_ff;
   logic [STEP_WIDTH-1:0] bar_step_cm_ff;

   // Sequencer state.
   phase_type             phase_ff, phase_in;
   logic [TPMS_WIDTH-1:0] tick_count_ff, tick_count_in;
   logic [MS_WIDTH-1:0]   ms_count_ff, ms_count_in;
   logic [TPCM_WIDTH-1:0] cm_tick_count_ff, cm_tick_count_in;
   logic [DIST_WIDTH-1:0] cm_count_ff, cm_count_in;
   logic                  trigger_level_ff, trigger_level_in;
   logic [DIST_WIDTH-1:0] saved_distance_ff, saved_distance_in;

   // Result register.
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   logic                  req_accept;
   logic [MS_WIDTH-1:0]   duration;
   logic                  tick_last;
   logic                  ms_last;
   logic [TPCM_WIDTH-1:0] cm_tick_base;
   logic [DIST_WIDTH-1:0] cm_base;
   logic                  cm_tick_last;
   logic [TPCM_WIDTH-1:0] cm_tick_step;
   logic [DIST_WIDTH-1:0] cm_step;
   logic [LED_COUNT-1:0]  bar_pattern;

   // The result register frees up when it is empty or being taken.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Millisecond timer: the duration follows the timed phase.
   always_comb begin
      unique case (phase_ff)
         PH_TRIG_HIGH: duration = trigger_ms_ff;
         PH_BAR:       duration = bar_ms_ff;
         default:      duration = flash_ms_ff;
      endcase
   end

   assign tick_last = ({1'b0, tick_count_ff} + (TPMS_WIDTH+1)'(1)) >= {1'b0, ticks_per_ms_ff};
   assign ms_last   = ({1'b0, ms_count_ff} + (MS_WIDTH+1)'(1)) >= {1'b0, duration};

   // Echo tick counter; the rising-edge beat restarts from zero.
   assign cm_tick_base = (phase_ff == PH_WAIT_RISE) ? '0 : cm_tick_count_ff;
   assign cm_base      = (phase_ff == PH_WAIT_RISE) ? '0 : cm_count_ff;
   assign cm_tick_last = ({1'b0, cm_tick_base} + (TPCM_WIDTH+1)'(1))
                         >= {1'b0, ticks_per_cm_ff};

   always_comb begin
      if (cm_tick_last) begin
         cm_tick_step = '0;
         cm_step      = (cm_base == DIST_MAX) ? cm_base : cm_base + DIST_WIDTH'(1);
      end else begin
         cm_tick_step = cm_tick_base + TPCM_WIDTH'(1);
         cm_step      = cm_base;
      end
   end

   urbs_bar u_bar (
      .distance (saved_distance_ff),
      .step_cm  (bar_step_cm_ff),
      .bar      (bar_pattern)
   );

   // Next state and result for one sample beat.
   always_comb begin
      logic timer_done;
      logic timer_run;

      timer_done        = 1'b0;
      timer_run         = 1'b0;
      phase_in          = phase_ff;
      tick_count_in     = tick_count_ff;
      ms_count_in       = ms_count_ff;
      cm_tick_count_in  = cm_tick_count_ff;
      cm_count_in       = cm_count_ff;
      trigger_level_in  = trigger_level_ff;
      saved_distance_in = saved_distance_ff;
      rsp_data_in       = '0;
      rsp_data_in.trigger_out = trigger_level_ff;

      unique case (phase_ff)
         PH_FLASH_A, PH_TRIG_HIGH, PH_FLASH_B, PH_BAR: timer_run = 1'b1;
         default:                                      timer_run = 1'b0;
      endcase

      if (timer_run) begin
         if (tick_last) begin
            tick_count_in = '0;
            if (ms_last) begin
               ms_count_in = '0;
               timer_done  = 1'b1;
            end else begin
               ms_count_in = ms_count_ff + MS_WIDTH'(1);
            end
         end else begin
            tick_count_in = tick_count_ff + TPMS_WIDTH'(1);
         end
      end

      unique case (phase_ff)
         PH_WAIT_LEFT: begin
            if (req_data.swing_level) begin
               tick_count_in = '0;
               ms_count_in   = '0;
               phase_in      = PH_FLASH_A;
            end
         end
         PH_FLASH_A: begin
            rsp_data_in.led_pattern = LED_ALL;
            if (timer_done) begin
               trigger_level_in = 1'b1;
               phase_in         = PH_TRIG_HIGH;
            end
         end
         PH_TRIG_HIGH: begin
            if (timer_done) begin
               trigger_level_in = 1'b0;
               phase_in         = PH_WAIT_RISE;
            end
         end
         PH_WAIT_RISE, PH_MEASURE: begin
            if (req_data.echo_level) begin
               cm_tick_count_in = cm_tick_step;
               cm_count_in      = cm_step;
               phase_in         = PH_MEASURE;
            end else if (phase_ff == PH_MEASURE) begin
               saved_distance_in          = cm_count_ff;
               rsp_data_in.distance_valid = 1'b1;
               phase_in                   = PH_WAIT_RIGHT;
            end
         end
         PH_WAIT_RIGHT: begin
            if (!req_data.swing_level) begin
               tick_count_in = '0;
               ms_count_in   = '0;
               phase_in      = PH_FLASH_B;
            end
         end
         PH_FLASH_B: begin
            rsp_data_in.led_pattern = LED_ALL;
            if (timer_done) begin
               phase_in = PH_BAR;
            end
         end
         PH_BAR: begin
            rsp_data_in.led_pattern = bar_pattern;
            if (timer_done) begin
               phase_in = PH_WAIT_LEFT;
            end
         end
      endcase

      rsp_data_in.range_cm = saved_distance_in;
   end

   // State, configuration and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_ms_ff   <= TICKS_PER_MS_RESET;
         trigger_ms_ff     <= TRIGGER_MS_RESET;
         flash_ms_ff       <= FLASH_MS_RESET;
         bar_ms_ff         <= BAR_MS_RESET;
         ticks_per_cm_ff   <= TICKS_PER_CM_RESET;
         bar_step_cm_ff    <= BAR_STEP_CM_RESET;
         phase_ff          <= PH_WAIT_LEFT;
         tick_count_ff     <= '0;
         ms_count_ff       <= '0;
         cm_tick_count_ff  <= '0;
         cm_count_ff       <= '0;
         trigger_level_ff  <= 1'b1;
         saved_distance_ff <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_TICKS_PER_MS: ticks_per_ms_ff <= csr_wdata[TPMS_WIDTH-1:0];
               CSR_TRIGGER_MS:   trigger_ms_ff   <= csr_wdata[MS_WIDTH-1:0];
               CSR_FLASH_MS:     flash_ms_ff     <= csr_wdata[MS_WIDTH-1:0];
               CSR_BAR_MS:       bar_ms_ff       <= csr_wdata[MS_WIDTH-1:0];
               CSR_TICKS_PER_CM: ticks_per_cm_ff <= csr_wdata[TPCM_WIDTH-1:0];
               CSR_BAR_STEP_CM:  bar_step_cm_ff  <= csr_wdata[STEP_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_accept) begin
            phase_ff          <= phase_in;
            tick_count_ff     <= tick_count_in;
            ms_count_ff       <= ms_count_in;
            cm_tick_count_ff  <= cm_tick_count_in;
            cm_count_ff       <= cm_count_in;
            trigger_level_ff  <= trigger_level_in;
            saved_distance_ff <= saved_distance_in;
            rsp_valid_ff      <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // The trigger is always released while the echo is being timed.
   a_measure_trigger_low : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_MEASURE || phase_ff == PH_WAIT_RISE) |-> !trigger_level_ff)
      else $error("trigger high while waiting for or timing the echo");

   // The millisecond timer rests at zero outside the timed phases.
   a_timer_idle : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_WAIT_LEFT || phase_ff == PH_WAIT_RISE ||
       phase_ff == PH_MEASURE || phase_ff == PH_WAIT_RIGHT)
      |-> (tick_count_ff == '0 && ms_count_ff == '0))
      else $error("timer not cleared outside a timed phase");

   // A distance beat comes with the LEDs dark and the trigger released.
   a_distance_beat : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.distance_valid)
      |-> (rsp_data_ff.led_pattern == '0 && !rsp_data_ff.trigger_out))
      else $error("distance beat with LEDs or trigger active");

   // A stalled result beat is held until it is taken.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("stalled result beat dropped or changed");

endmodule
